// ----- rtl/gha_pkg.sv -----
// Shared constants, command and status codes, and controller command type for the handle allocator.
`default_nettype none

package gha_pkg;

    // Table size and generation width of the allocator.
    localparam int MAX_HANDLES = 1024;
    localparam int GEN_BITS    = 16;

    // Fixed widths of the handle fields on the ports.
    localparam int IDX_FIELD_W = 10;
    localparam int GEN_FIELD_W = 16;

    // Derived widths: slot address, counters that can hold MAX_HANDLES, compare widths.
    localparam int IDX_W    = $clog2(MAX_HANDLES);
    localparam int CNT_W    = $clog2(MAX_HANDLES + 1);
    localparam int IDXCMP_W = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;
    localparam int GCMP_W   = (GEN_BITS > GEN_FIELD_W) ? GEN_BITS : GEN_FIELD_W;

    // Request codes.
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // request transfer taken; start table reads
        logic commit;   // decide, update tables, load the response register
    } gha_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/gha_ctrl.sv -----
// Request sequencer: accepts a request, then commits it once the response register is free.
`default_nettype none

module gha_ctrl
    import gha_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output gha_cmd_t      ctrl_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;

    assign req_stall        = (state_reg != S_IDLE);
    assign ctrl_cmd.accept  = (state_reg == S_IDLE) && req_valid;
    assign ctrl_cmd.commit  = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid        = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (ctrl_cmd.commit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (ctrl_cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gha_datapath.sv -----
// Generation table, free stack, allocation counters and response register of the handle allocator.
`default_nettype none

module gha_datapath
    import gha_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire gha_cmd_t                  ctrl_cmd,
    input  wire logic [1:0]                cmd,
    input  wire logic [IDX_FIELD_W-1:0]    handle_index,
    input  wire logic [GEN_FIELD_W-1:0]    handle_generation,
    output logic [1:0]                     status,
    output logic [IDX_FIELD_W-1:0]         out_index,
    output logic [GEN_FIELD_W-1:0]         out_generation,
    output logic                           is_valid
);

    logic [GEN_BITS-1:0]    gen_mem [MAX_HANDLES];
    logic [IDX_W-1:0]       stk_mem [MAX_HANDLES];

    logic [1:0]             cmd_reg;
    logic [IDX_FIELD_W-1:0] idx_reg;
    logic [GEN_FIELD_W-1:0] gin_reg;
    logic [GEN_BITS-1:0]    gen_rd_reg;
    logic [IDX_W-1:0]       top_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       fresh_reg;
    logic [CNT_W-1:0]       fresh_next;

    logic [1:0]             status_reg;
    logic [IDX_FIELD_W-1:0] oidx_reg;
    logic [GEN_FIELD_W-1:0] ogen_reg;
    logic                   ovalid_reg;

    logic [1:0]             status_next;
    logic [IDX_FIELD_W-1:0] oidx_next;
    logic [GEN_FIELD_W-1:0] ogen_next;
    logic                   ovalid_next;

    logic [IDX_W-1:0]       gen_ra;
    logic                   gen_we;
    logic [IDX_W-1:0]       gen_wa;
    logic [GEN_BITS-1:0]    gen_wd;
    logic                   push;
    logic [IDX_W-1:0]       idx_addr;
    logic [IDX_W-1:0]       top_ra;
    logic                   handle_ok;
    logic                   stack_empty;
    logic                   stack_full;
    logic                   fresh_left;

    // On an allocate with freed slots waiting, the generation read goes to the stack top.
    assign stack_empty = (count_reg == '0);
    assign gen_ra      = (cmd == CMD_ALLOC && !stack_empty) ? top_reg : IDX_W'(handle_index);

    assign idx_addr    = IDX_W'(idx_reg);
    assign stack_full  = (count_reg == CNT_W'(MAX_HANDLES));
    assign fresh_left  = (fresh_reg < CNT_W'(MAX_HANDLES));
    assign handle_ok   = (idx_reg != '0)
                      && (IDXCMP_W'(idx_reg) < IDXCMP_W'(fresh_reg))
                      && (GCMP_W'(gen_rd_reg) == GCMP_W'(gin_reg));

    always_comb
    begin
        status_next = ST_INVALID;
        oidx_next   = idx_reg;
        ogen_next   = gin_reg;
        ovalid_next = 1'b0;
        count_next  = count_reg;
        fresh_next  = fresh_reg;
        gen_we      = 1'b0;
        gen_wa      = idx_addr;
        gen_wd      = gen_rd_reg + GEN_BITS'(1);
        push        = 1'b0;

        if (ctrl_cmd.commit)
        begin
            unique case (cmd_reg)
                CMD_ALLOC:
                begin
                    if (!stack_empty)
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        status_next = ST_OK;
                        oidx_next   = IDX_FIELD_W'(top_reg);
                        ogen_next   = GEN_FIELD_W'(gen_rd_reg);
                    end
                    else if (fresh_left)
                    begin
                        // A never-used slot starts at generation zero.
                        fresh_next  = fresh_reg + CNT_W'(1);
                        gen_we      = 1'b1;
                        gen_wa      = IDX_W'(fresh_reg);
                        gen_wd      = '0;
                        status_next = ST_OK;
                        oidx_next   = IDX_FIELD_W'(fresh_reg);
                        ogen_next   = '0;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                CMD_FREE:
                begin
                    if (handle_ok)
                    begin
                        gen_we      = 1'b1;
                        status_next = ST_OK;
                        ovalid_next = 1'b1;
                        if (!stack_full)
                        begin
                            push       = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                CMD_CHECK:
                begin
                    status_next = handle_ok ? ST_OK : ST_INVALID;
                    ovalid_next = handle_ok;
                end
                default:
                begin
                    status_next = ST_INVALID;
                end
            endcase
        end
    end

    // The stack top register always tracks the entry below the next count.
    assign top_ra = IDX_W'(count_next - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[gen_wa] <= gen_wd;
        end
        if (ctrl_cmd.accept)
        begin
            gen_rd_reg <= gen_mem[gen_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_mem[count_reg[IDX_W-1:0]] <= idx_addr;
            top_reg                       <= idx_addr;
        end
        else
        begin
            top_reg <= stk_mem[top_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fresh_reg <= CNT_W'(1);
        end
        else
        begin
            count_reg <= count_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.accept)
        begin
            cmd_reg <= cmd;
            idx_reg <= handle_index;
            gin_reg <= handle_generation;
        end
        if (ctrl_cmd.commit)
        begin
            status_reg <= status_next;
            oidx_reg   <= oidx_next;
            ogen_reg   <= ogen_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign status         = status_reg;
    assign out_index      = oidx_reg;
    assign out_generation = ogen_reg;
    assign is_valid       = ovalid_reg;

endmodule

`default_nettype wire

// ----- rtl/generational_handle_allocator.sv -----
// Top level of the generational handle allocator: controller, datapath and checks.
`default_nettype none

// The allocator hands out handles made of a slot index and a generation, and answers
// allocate, free and check requests, one response per request. At the request transfer
// the generation table is read (at the handle's index, or at the top of the free stack
// for an allocate that reuses a freed slot); then, in the execute state and once the
// response register is free, the handle is judged and the generation table, the free
// stack and the counters are written, with the response loaded into the output register.
// The read and the write of the single-port generation table fall in separate states.
// The next request is taken while the response still waits to be transferred; the
// controller holds a finished request only when the previous response is still pending.
// Slot zero is reserved and never valid. Slots that were never issued are judged invalid
// from the fresh-slot counter alone, so no clearing pass runs after reset and the block
// takes requests from the first cycle. Once every fresh slot is issued and the free stack
// is empty, an allocate returns status full and changes nothing.

module generational_handle_allocator
    import gha_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_stall,
    input  wire logic [1:0]              cmd,
    input  wire logic [IDX_FIELD_W-1:0]  handle_index,
    input  wire logic [GEN_FIELD_W-1:0]  handle_generation,
    output logic                         rsp_valid,
    input  wire logic                    rsp_stall,
    output logic [1:0]                   status,
    output logic [IDX_FIELD_W-1:0]       out_index,
    output logic [GEN_FIELD_W-1:0]       out_generation,
    output logic                         is_valid
);

    gha_cmd_t ctrl_cmd;

    // The controller paces requests and owns the response valid flag.
    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctrl_cmd  (ctrl_cmd)
    );

    // The datapath holds the tables, the counters and the response register.
    gha_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl_cmd          (ctrl_cmd),
        .cmd               (cmd),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .status            (status),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .is_valid          (is_valid)
    );

    // A request transfer puts the controller into its execute state, so the next
    // request must be held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.accept |=> req_stall)
        else $error("request taken in back-to-back cycles");

    // Every commit leaves a response waiting on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |=> rsp_valid)
        else $error("commit without a response");

    // A response only appears after a commit.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(ctrl_cmd.commit))
        else $error("response without a commit");

    // A handle reported valid always comes with status ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_valid) |-> (status == ST_OK))
        else $error("valid handle with a failing status");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the generational handle allocator: stimulus, prediction and checks.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gha_pkg::*;

    // The unused fourth request code. The block must answer it as an invalid handle.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // Longest run of idle cycles that the request side inserts before one transfer.
    localparam int MAX_GAP = 40;

    // One response transfer, in port order.
    typedef struct packed {
        logic [1:0]             status;
        logic [IDX_FIELD_W-1:0] index;
        logic [GEN_FIELD_W-1:0] generation;
        logic                   valid_before;
    } response_t;

    // Keeps its own copy of the slot generations, the free stack and the fresh-slot
    // counter. Every accepted request is run through that copy at once, and the
    // response it must produce is queued until the block delivers it.
    class handle_scoreboard;
        logic [GEN_BITS-1:0] slot_generation [MAX_HANDLES];
        logic [IDX_W-1:0]    free_slots [MAX_HANDLES];
        int                  free_depth;
        int                  fresh_slot;
        response_t           pending_responses [$];
        int                  errors;

        function new();
            foreach (slot_generation[i])
                slot_generation[i] = '0;
            free_depth = 0;
            fresh_slot = 1;
            errors     = 0;
        endfunction

        // A handle is live when its slot has been issued (slot zero never is) and its
        // generation equals the one stored for that slot.
        function bit is_live(int idx, logic [GEN_FIELD_W-1:0] gen);
            return idx != 0 && idx < fresh_slot && idx < MAX_HANDLES
                && GCMP_W'(slot_generation[idx]) == GCMP_W'(gen);
        endfunction

        function void note_request(logic [1:0] op, logic [IDX_FIELD_W-1:0] idx,
                                   logic [GEN_FIELD_W-1:0] gen);
            response_t rsp;
            int        slot;
            bit        live;
            live = is_live(idx, gen);
            rsp  = '{status: ST_INVALID, index: idx, generation: gen, valid_before: 1'b0};
            case (op)
                CMD_ALLOC:
                begin
                    // A freed slot is reused first, else a fresh one is issued.
                    if (free_depth > 0)
                    begin
                        free_depth--;
                        slot = free_slots[free_depth];
                    end
                    else if (fresh_slot < MAX_HANDLES)
                    begin
                        slot = fresh_slot;
                        fresh_slot++;
                        slot_generation[slot] = '0;
                    end
                    else
                        slot = 0;
                    if (slot == 0)
                        rsp.status = ST_FULL;
                    else
                    begin
                        rsp.status     = ST_OK;
                        rsp.index      = IDX_FIELD_W'(slot);
                        rsp.generation = GEN_FIELD_W'(slot_generation[slot]);
                    end
                end
                CMD_FREE:
                begin
                    if (live)
                    begin
                        // The generation wraps at its own width. A push onto a full
                        // stack is dropped.
                        slot_generation[idx] = slot_generation[idx] + 1'b1;
                        if (free_depth < MAX_HANDLES)
                        begin
                            free_slots[free_depth] = IDX_W'(idx);
                            free_depth++;
                        end
                        rsp.status       = ST_OK;
                        rsp.valid_before = 1'b1;
                    end
                end
                CMD_CHECK:
                begin
                    if (live)
                    begin
                        rsp.status       = ST_OK;
                        rsp.valid_before = 1'b1;
                    end
                end
                default:
                    ;
            endcase
            pending_responses = {pending_responses, rsp};
        endfunction

        function void report(string what, response_t want, response_t got);
            errors++;
            if (errors <= 10)
                $display("%s: expected status=%0d index=%0d gen=%0d valid=%0b,",
                         what, want.status, want.index, want.generation, want.valid_before,
                         " got status=%0d index=%0d gen=%0d valid=%0b",
                         got.status, got.index, got.generation, got.valid_before);
        endfunction

        function void check_response(response_t got);
            response_t want;
            if (pending_responses.size() == 0)
            begin
                report("response with no request outstanding", '0, got);
                return;
            end
            want = pending_responses.pop_front();
            if (got.status !== want.status || got.index !== want.index
                || got.generation !== want.generation
                || got.valid_before !== want.valid_before)
                report("response mismatch", want, got);
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                   clk               = 1'b0;
    logic                   rst_n             = 1'b0;
    logic                   req_valid         = 1'b0;
    logic                   req_stall;
    logic [1:0]             cmd               = CMD_CHECK;
    logic [IDX_FIELD_W-1:0] handle_index      = '0;
    logic [GEN_FIELD_W-1:0] handle_generation = '0;
    logic                   rsp_valid;
    logic                   rsp_stall         = 1'b0;
    logic [1:0]             status;
    logic [IDX_FIELD_W-1:0] out_index;
    logic [GEN_FIELD_W-1:0] out_generation;
    logic                   is_valid;

    // Idling of both sides, in percent of cycles, and the long hold-off of the receiver.
    int                     tx_idle_pct       = 0;
    int                     rx_stall_pct      = 0;
    logic                   hold_off          = 1'b0;

    handle_scoreboard       sb = new();

    generational_handle_allocator u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .cmd               (cmd),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .status            (status),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .is_valid          (is_valid)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Response side. Everything is sampled right at the rising edge, so the values seen
    // are the ones the block presented during the cycle that just ended. A transfer
    // happened when valid was high and our stall was low. The stall for the next cycle
    // is then chosen at random, or forced high while a hold-off is running.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_response({status, out_index, out_generation, is_valid});
            rsp_stall <= hold_off || ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Offers one request and returns at the edge of its transfer, after the scoreboard
    // has taken it in. A random number of idle cycles goes first. When there is no gap,
    // valid simply stays high from the previous transfer.
    task automatic send_request(logic [1:0] op, logic [IDX_FIELD_W-1:0] idx,
                                logic [GEN_FIELD_W-1:0] gen);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid         <= 1'b1;
        cmd               <= op;
        handle_index      <= idx;
        handle_generation <= gen;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(op, idx, gen);
    endtask

    // Holds the response side off for a fixed number of cycles. It runs in a process
    // of its own while the request side keeps offering, so that the response register
    // and then the request pipeline fill and the block has to stall its input.
    task automatic hold_receiver(int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    // One random request. Most requests use a handle that is live right now: in this
    // scheme every issued slot stays live under its current generation, freed or not.
    // The rest are stale handles one to three generations behind and pure noise over
    // the whole range of every field, the unused request code among them.
    task automatic random_request(int alloc_pct);
        int                     r;
        int                     idx;
        logic [GEN_FIELD_W-1:0] gen;
        r = $urandom_range(99);
        if (r < alloc_pct || sb.fresh_slot == 1)
        begin
            send_request(CMD_ALLOC, IDX_FIELD_W'($urandom), GEN_FIELD_W'($urandom));
            return;
        end
        idx = $urandom_range(sb.fresh_slot - 1, 1);
        gen = GEN_FIELD_W'(sb.slot_generation[idx]);
        r   = $urandom_range(99);
        if (r < 35)
            send_request(CMD_FREE, IDX_FIELD_W'(idx), gen);
        else if (r < 60)
            send_request(CMD_CHECK, IDX_FIELD_W'(idx), gen);
        else if (r < 80)
            send_request($urandom_range(1) ? CMD_FREE : CMD_CHECK, IDX_FIELD_W'(idx),
                         gen - GEN_FIELD_W'($urandom_range(3, 1)));
        else
            send_request(2'($urandom_range(3)), IDX_FIELD_W'($urandom),
                         GEN_FIELD_W'($urandom));
    endtask

    task automatic set_idling(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening, with no idling on either side. Slot zero is never valid,
        // slots not yet issued are invalid, and field extremes show up in both fields.
        send_request(CMD_CHECK, '0, '0);
        send_request(CMD_FREE, '0, '0);
        send_request(CMD_CHECK, '1, '1);
        send_request(CMD_ALLOC, '1, '1);        // first fresh slot, generation zero
        send_request(CMD_CHECK, 10'd1, '0);
        send_request(CMD_CHECK, 10'd1, '1);
        send_request(CMD_FREE, 10'd1, '0);
        send_request(CMD_CHECK, 10'd1, '0);     // stale after the free
        send_request(CMD_FREE, 10'd1, '0);      // freeing a stale handle changes nothing
        send_request(CMD_ALLOC, '0, '0);        // reuses the freed slot
        send_request(CMD_ALLOC, '0, '0);        // stack empty again, next fresh slot
        send_request(CMD_UNKNOWN, 10'd2, '0);
        send_request(CMD_FREE, 10'd2, '1);
        send_request(CMD_FREE, 10'd1, 16'd1);
        send_request(CMD_FREE, 10'd1, 16'd2);   // the bumped handle frees the slot twice
        send_request(CMD_ALLOC, '0, '0);
        send_request(CMD_ALLOC, '0, '0);        // same slot handed out a second time
        send_request(CMD_ALLOC, '0, '0);
        send_request(CMD_CHECK, 10'd3, '0);
        send_request(CMD_FREE, '1, '0);

        // Random traffic under each kind of idling.
        set_idling(0, 0);
        repeat (200) random_request(50);

        set_idling(78, 0);
        repeat (200) random_request(50);

        set_idling(0, 78);
        fork
            hold_receiver(300);
        join_none
        repeat (200) random_request(50);

        // With both sides idling a little, allocate until no slot is left, then keep
        // asking so that the table-full answer is seen, then mix again at full.
        set_idling(11, 11);
        while (sb.free_depth > 0 || sb.fresh_slot < MAX_HANDLES)
        begin
            if ($urandom_range(7) == 0)
                random_request(50);
            else
                send_request(CMD_ALLOC, IDX_FIELD_W'($urandom), GEN_FIELD_W'($urandom));
        end
        repeat (20) send_request(CMD_ALLOC, IDX_FIELD_W'($urandom), GEN_FIELD_W'($urandom));
        repeat (200) random_request(40);

        // Drain: stop offering, let the receiver take everything, then keep watching the block
        // for any response that should not be there.
        req_valid <= 1'b0;
        rx_stall_pct <= 0;
        while (sb.pending_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: ends a run that has not finished by this time with an error.
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- generational_handle_allocator.f -----
rtl/gha_pkg.sv
rtl/gha_ctrl.sv
rtl/gha_datapath.sv
rtl/generational_handle_allocator.sv
dv/tb_top.sv
